// ===== sv/rmst_pkg.sv =====
package rmst_pkg;

    localparam int POS_W            = 11;
    localparam int VAL_W            = 64;
    localparam int LEN_W            = 11;
    localparam int MAX_ELEMENTS_DEF = 1024;

    localparam logic signed [VAL_W-1:0] EMPTY_MIN = 64'sd999999999999;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_WDOWN  = 8'b0000_0100,
        S_WRD    = 8'b0000_1000,
        S_WUP    = 8'b0001_0000,
        S_QVISIT = 8'b0010_0000,
        S_QACC   = 8'b0100_0000,
        S_QDONE  = 8'b1000_0000
    } t_state;

endpackage

// ===== sv/rmst_ram.sv =====
module rmst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/range_minimum_segment_tree_top.sv =====
// Channel   Direction  Handshake                    Contents
// input     in         i_valid / o_stall            request type, index, value, range
// output    out        o_valid / i_stall            range minimum
// config    in         i_cfg_valid / o_cfg_ready    active length
//
// A write walks down one tree level per S_WDOWN step and writes the leaf,
// then climbs with a sibling read (S_WRD) and a parent write (S_WUP) per level.
// A query visits up to about 4 nodes per level; each node fully inside the range is read
// in S_QVISIT and folded in S_QACC; S_QDONE posts the result. The RAM has one port pair.
// After reset the tree RAM is cleared one entry per cycle, all 4 * MAX_ELEMENTS entries,
// and no input transaction is accepted meanwhile.
// A finished query waits in the output register; a new transaction may be accepted
// while it is stalled, but the next query result waits until the register is free.
module range_minimum_segment_tree_top
    import rmst_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_req_type,
    input  logic [POS_W-1:0]        i_element_index,
    input  logic signed [VAL_W-1:0] i_new_value,
    input  logic [POS_W-1:0]        i_range_left,
    input  logic [POS_W-1:0]        i_range_right,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [VAL_W-1:0] o_range_minimum,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [LEN_W-1:0]        i_cfg_active_length
);

    localparam int DEPTH = 4 * MAX_ELEMENTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(MAX_ELEMENTS + 1);
    localparam int CW    = (PW > POS_W) ? PW : POS_W;
    localparam int SD    = $clog2(MAX_ELEMENTS) + 1;
    localparam int SIW   = (SD > 1) ? $clog2(SD) : 1;
    localparam int SPW   = $clog2(SD + 1);

    typedef struct packed {
        logic [AW-1:0] v;
        logic [CW-1:0] lo;
        logic [CW-1:0] hi;
    } t_frame;

    t_state r_state, n_state;

    logic [LEN_W-1:0]        r_active_length;
    logic [AW-1:0]           r_v, n_v;
    logic [CW-1:0]           r_lo, n_lo;
    logic [CW-1:0]           r_hi, n_hi;
    logic [CW-1:0]           r_pos, n_pos;
    logic [CW-1:0]           r_l, n_l;
    logic [CW-1:0]           r_r, n_r;
    logic signed [VAL_W-1:0] r_val, n_val;
    logic [SPW-1:0]          r_sp, n_sp;
    t_frame                  r_stk [SD];
    logic                    stk_push;
    t_frame                  stk_wdata;
    logic                    r_out_valid, n_out_valid;
    logic signed [VAL_W-1:0] r_out_data, n_out_data;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [VAL_W-1:0]        ram_wdata;
    logic                    ram_re;
    logic [AW-1:0]           ram_raddr;
    logic [VAL_W-1:0]        ram_rdata;
    logic signed [VAL_W-1:0] rd_val;

    logic [CW-1:0]           len_ext;
    logic [CW-1:0]           span_n;
    logic [CW:0]             mid_sum;
    logic [CW-1:0]           mid;
    logic [AW-1:0]           left_child;
    logic [AW-1:0]           right_child;
    logic [AW-1:0]           parent;
    logic signed [VAL_W-1:0] min_val;
    logic                    in_acc;
    t_frame                  top_frame;

    rmst_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_tree_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_val      = ram_rdata;
    assign in_acc      = i_valid && !o_stall;
    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_range_minimum = r_out_data;
    assign o_cfg_ready = 1'b1;

    assign len_ext     = CW'(r_active_length);
    assign mid_sum     = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid         = mid_sum[CW:1];
    assign left_child  = {r_v[AW-2:0], 1'b0};
    assign right_child = {r_v[AW-2:0], 1'b1};
    assign parent      = {1'b0, r_v[AW-1:1]};
    assign min_val     = (r_val < rd_val) ? r_val : rd_val;
    assign top_frame   = r_stk[SIW'(r_sp - SPW'(1))];

    always_comb begin
        if (len_ext == '0) begin
            span_n = CW'(1);
        end else if (len_ext > CW'(MAX_ELEMENTS)) begin
            span_n = CW'(MAX_ELEMENTS);
        end else begin
            span_n = len_ext;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_v         = r_v;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_pos       = r_pos;
        n_l         = r_l;
        n_r         = r_r;
        n_val       = r_val;
        n_sp        = r_sp;
        stk_push    = 1'b0;
        stk_wdata   = '{v: right_child, lo: mid + CW'(1), hi: r_hi};
        n_out_valid = r_out_valid && i_stall;
        n_out_data  = r_out_data;
        ram_we      = 1'b0;
        ram_waddr   = r_v;
        ram_wdata   = r_val;
        ram_re      = 1'b0;
        ram_raddr   = r_v;

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                n_v       = r_v + AW'(1);
                if (r_v == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_v   = AW'(1);
                    n_lo  = CW'(1);
                    n_hi  = span_n;
                    n_pos = CW'(i_element_index);
                    n_l   = CW'(i_range_left);
                    n_r   = CW'(i_range_right);
                    n_sp  = '0;
                    if (i_req_type == REQ_QUERY) begin
                        n_val   = EMPTY_MIN;
                        n_state = S_QVISIT;
                    end else begin
                        n_val = i_new_value;
                        if (CW'(i_element_index) >= CW'(1)
                            && CW'(i_element_index) <= span_n) begin
                            n_state = S_WDOWN;
                        end
                    end
                end
            end
            S_WDOWN: begin
                if (r_lo == r_hi) begin
                    ram_we = 1'b1;
                    if (r_v == AW'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_WRD;
                    end
                end else if (r_pos <= mid) begin
                    n_v  = left_child;
                    n_hi = mid;
                end else begin
                    n_v  = right_child;
                    n_lo = mid + CW'(1);
                end
            end
            S_WRD: begin
                ram_re    = 1'b1;
                ram_raddr = {r_v[AW-1:1], ~r_v[0]};
                n_state   = S_WUP;
            end
            S_WUP: begin
                ram_we    = 1'b1;
                ram_waddr = parent;
                ram_wdata = min_val;
                n_val     = min_val;
                n_v       = parent;
                if (parent == AW'(1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_WRD;
                end
            end
            S_QVISIT: begin
                if (r_hi < r_l || r_r < r_lo) begin
                    if (r_sp == '0) begin
                        n_state = S_QDONE;
                    end else begin
                        n_v  = top_frame.v;
                        n_lo = top_frame.lo;
                        n_hi = top_frame.hi;
                        n_sp = r_sp - SPW'(1);
                    end
                end else if (r_l <= r_lo && r_hi <= r_r) begin
                    ram_re  = 1'b1;
                    n_state = S_QACC;
                end else begin
                    stk_push = 1'b1;
                    n_sp     = r_sp + SPW'(1);
                    n_v      = left_child;
                    n_hi     = mid;
                end
            end
            S_QACC: begin
                // A range that covers the root returns the root itself, without the sentinel.
                n_val = (r_v == AW'(1)) ? rd_val : min_val;
                if (r_sp == '0) begin
                    n_state = S_QDONE;
                end else begin
                    n_v     = top_frame.v;
                    n_lo    = top_frame.lo;
                    n_hi    = top_frame.hi;
                    n_sp    = r_sp - SPW'(1);
                    n_state = S_QVISIT;
                end
            end
            S_QDONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_val;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_CLEAR;
            r_v             <= '0;
            r_sp            <= '0;
            r_out_valid     <= 1'b0;
            r_active_length <= LEN_W'(1);
        end else begin
            r_state     <= n_state;
            r_v         <= n_v;
            r_sp        <= n_sp;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_active_length <= i_cfg_active_length;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_pos      <= n_pos;
        r_l        <= n_l;
        r_r        <= n_r;
        r_val      <= n_val;
        r_out_data <= n_out_data;
        if (stk_push) begin
            r_stk[SIW'(r_sp)] <= stk_wdata;
        end
    end

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_QDONE))
        else $error("Result appeared without a finished query.");

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(SD))
        else $error("Query stack overflow.");

    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req_type == REQ_WRITE && !o_valid) |=> !o_valid)
        else $error("Write transaction produced a result.");

    a_query_no_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QVISIT || r_state == S_QACC) |-> !ram_we)
        else $error("Tree store written during a query.");

endmodule

// ===== test/tb_top.sv =====
module tb_top
    import rmst_pkg::*;
();

    localparam int NODE_SLOTS    = 4 * MAX_ELEMENTS_DEF;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 200;
    localparam int PHASE_ITEMS   = 130;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic                    req_type;
        logic [POS_W-1:0]        element_index;
        logic signed [VAL_W-1:0] new_value;
        logic [POS_W-1:0]        range_left;
        logic [POS_W-1:0]        range_right;
    } t_request;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic                    i_req_type = 1'b0;
    logic [POS_W-1:0]        i_element_index = '0;
    logic signed [VAL_W-1:0] i_new_value = '0;
    logic [POS_W-1:0]        i_range_left = '0;
    logic [POS_W-1:0]        i_range_right = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic signed [VAL_W-1:0] o_range_minimum;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [LEN_W-1:0]        i_cfg_active_length = '0;

    logic signed [VAL_W-1:0] node_min [0:NODE_SLOTS-1];
    logic [LEN_W-1:0]        active_length_reg = LEN_W'(1);

    t_request                pending_requests [$];
    t_request                in_flight;
    logic signed [VAL_W-1:0] expected_minima [$];

    int idle_pct = 20;
    int stall_pct = 20;
    int mismatch_count = 0;
    int cycle_count = 0;

    range_minimum_segment_tree_top dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int unsigned covered_span(logic [LEN_W-1:0] len);
        if (len == 0) return 1;
        if (len > MAX_ELEMENTS_DEF) return MAX_ELEMENTS_DEF;
        return len;
    endfunction

    function automatic logic signed [VAL_W-1:0] node_value(int unsigned node);
        return (node < NODE_SLOTS) ? node_min[node] : '0;
    endfunction

    function automatic logic signed [VAL_W-1:0] smaller(logic signed [VAL_W-1:0] a,
                                                        logic signed [VAL_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic void store_element(int unsigned node, int unsigned lo, int unsigned hi,
                                          int unsigned pos, logic signed [VAL_W-1:0] x);
        int unsigned mid;
        if (pos < lo || pos > hi) return;
        if (lo == hi) begin
            if (node < NODE_SLOTS) node_min[node] = x;
            return;
        end
        mid = (lo + hi) / 2;
        store_element(2 * node, lo, mid, pos, x);
        store_element(2 * node + 1, mid + 1, hi, pos, x);
        if (node < NODE_SLOTS) node_min[node] = smaller(node_value(2 * node),
                                                        node_value(2 * node + 1));
    endfunction

    function automatic logic signed [VAL_W-1:0] range_min_over(int unsigned node,
                                                               int unsigned lo,
                                                               int unsigned hi,
                                                               int unsigned l,
                                                               int unsigned r);
        int unsigned mid;
        if (hi < l || r < lo) return EMPTY_MIN;
        if (l <= lo && hi <= r) return node_value(node);
        mid = (lo + hi) / 2;
        return smaller(range_min_over(2 * node, lo, mid, l, r),
                       range_min_over(2 * node + 1, mid + 1, hi, l, r));
    endfunction

    function automatic t_request random_request(int unsigned span);
        t_request rq;
        int unsigned a;
        int unsigned b;
        int unsigned t;
        rq.req_type = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 85) rq.element_index = POS_W'($urandom_range(1, span));
        else rq.element_index = POS_W'($urandom_range(0, 2047));
        case ($urandom_range(0, 3))
            0: begin
                rq.new_value = VAL_W'($urandom_range(0, 100));
                rq.new_value = rq.new_value - 50;
            end
            1: rq.new_value = $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
            default: rq.new_value = {$urandom, $urandom};
        endcase
        t = $urandom_range(0, 9);
        if (t < 8) begin
            a = $urandom_range(1, span);
            b = $urandom_range(1, span);
            rq.range_left  = POS_W'((a < b) ? a : b);
            rq.range_right = POS_W'((a < b) ? b : a);
        end else if (t == 8) begin
            rq.range_left  = POS_W'($urandom_range(0, 2047));
            rq.range_right = POS_W'($urandom_range(0, 2047));
        end else begin
            a = $urandom_range(1, 2047);
            b = $urandom_range(0, a - 1);
            rq.range_left  = POS_W'(a);
            rq.range_right = POS_W'(b);
        end
        return rq;
    endfunction

    task automatic queue_write(int unsigned idx, logic signed [VAL_W-1:0] x);
        t_request rq;
        rq.req_type      = REQ_WRITE;
        rq.element_index = POS_W'(idx);
        rq.new_value     = x;
        rq.range_left    = '1;
        rq.range_right   = '0;
        pending_requests.push_back(rq);
    endtask

    task automatic queue_query(int unsigned l, int unsigned r);
        t_request rq;
        rq.req_type      = REQ_QUERY;
        rq.element_index = '1;
        rq.new_value     = VAL_MIN;
        rq.range_left    = POS_W'(l);
        rq.range_right   = POS_W'(r);
        pending_requests.push_back(rq);
    endtask

    task automatic write_length(logic [LEN_W-1:0] len);
        @(posedge i_clk);
        i_cfg_valid         <= 1'b1;
        i_cfg_active_length <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        active_length_reg = len;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain_and_settle();
        while (pending_requests.size() != 0 || i_valid || expected_minima.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                if (in_flight.req_type == REQ_WRITE) begin
                    store_element(1, 1, covered_span(active_length_reg),
                                  in_flight.element_index, in_flight.new_value);
                end else begin
                    expected_minima.push_back(range_min_over(1, 1,
                        covered_span(active_length_reg),
                        in_flight.range_left, in_flight.range_right));
                end
            end
            if (!i_valid || !o_stall) begin
                if (pending_requests.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    in_flight = pending_requests.pop_front();
                    i_req_type      <= in_flight.req_type;
                    i_element_index <= in_flight.element_index;
                    i_new_value     <= in_flight.new_value;
                    i_range_left    <= in_flight.range_left;
                    i_range_right   <= in_flight.range_right;
                    i_valid         <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_minima.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("Unexpected transaction: range minimum %0d", o_range_minimum);
                    mismatch_count++;
                end else if (o_range_minimum !== expected_minima[0]) begin
                    if (mismatch_count < 10)
                        $display("Range minimum mismatch: expected %0d, actual %0d",
                                 expected_minima[0], o_range_minimum);
                    mismatch_count++;
                    void'(expected_minima.pop_front());
                end else begin
                    void'(expected_minima.pop_front());
                end
            end
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int unsigned lengths [8];
        int unsigned span;
        for (int i = 0; i < NODE_SLOTS; i++) node_min[i] = '0;
        lengths = '{1024, 1, 0, 37, 2047, 5, 0, 1024};
        lengths[6] = $urandom_range(2, 1024);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_length(LEN_W'(8));
        queue_query(1, 8);
        queue_write(1, VAL_MIN);
        queue_write(8, VAL_MAX);
        queue_write(4, -1);
        queue_write(0, VAL_MIN);
        queue_write(9, VAL_MIN);
        queue_write(2047, VAL_MIN);
        queue_write(5, EMPTY_MIN);
        queue_query(1, 8);
        queue_query(8, 8);
        queue_query(2, 3);
        queue_query(5, 5);
        queue_query(4, 8);
        queue_query(5, 1);
        queue_query(9, 2047);
        queue_query(0, 0);
        queue_query(0, 2047);
        queue_query(7, 2047);
        queue_query(2047, 0);
        queue_write(1, 7);
        queue_query(1, 3);
        drain_and_settle();

        foreach (lengths[p]) begin
            if (p == 7) begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            write_length(LEN_W'(lengths[p]));
            span = covered_span(LEN_W'(lengths[p]));
            for (int k = 0; k < PHASE_ITEMS; k++)
                pending_requests.push_back(random_request(span));
            drain_and_settle();
        end

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/rmst_pkg.sv
sv/rmst_ram.sv
sv/range_minimum_segment_tree_top.sv
test/tb_top.sv
